// ===== rtl/core/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Types and constants shared by the stream duplicate filter modules.
// ----------------------------------------------------------------------------
package sdf_pkg;

   localparam int VALUE_WIDTH = 32;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value_out;
      logic                          keep;
      logic                          last_out;
      logic                          overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic search_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/sdf_ram.sv =====
// ----------------------------------------------------------------------------
// sdf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/core/sdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdf_ctrl
// Controller for the duplicate filter: accepts an item, runs the search and
// commits the decision once the output register can take the result.
// ----------------------------------------------------------------------------
module sdf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  sdf_pkg::status_type status,
   output sdf_pkg::cmd_type    cmd
);
   import sdf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.search_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
         end
         ST_DECIDE: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/sdf_dpath.sv =====
// ----------------------------------------------------------------------------
// sdf_dpath
// Datapath for the duplicate filter: item register, store of seen values,
// search counter, comparator, fill count and output register.
// ----------------------------------------------------------------------------
module sdf_dpath #(
   parameter int SEEN_DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  sdf_pkg::req_type    req_data,
   input  sdf_pkg::cmd_type    cmd,
   output sdf_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output sdf_pkg::rsp_type    rsp_data
);
   import sdf_pkg::*;

   localparam int AW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
   localparam int CW = $clog2(SEEN_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(SEEN_DEPTH);

   req_type               item_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  pending_ff, pending_in;
   logic                  found_ff, found_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff;
   logic                  rd_en;
   logic                  wr_en;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                  store_full;

   assign store_full = (count_ff >= FULL_COUNT);
   assign rd_en      = cmd.step && (rd_idx_ff < count_ff);
   assign wr_en      = cmd.commit && !found_ff && !store_full;

   sdf_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (SEEN_DEPTH)
   ) u_seen_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[AW-1:0]),
      .wr_data    (item_ff.value),
      .rd_en      (rd_en),
      .rd_addr    (rd_idx_ff[AW-1:0]),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      rd_idx_in  = rd_idx_ff;
      pending_in = 1'b0;
      found_in   = found_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         found_in  = 1'b0;
      end else if (cmd.step) begin
         pending_in = rd_en;
         if (rd_en) begin
            rd_idx_in = rd_idx_ff + CW'(1);
         end
         if (pending_ff && (rd_data == item_ff.value)) begin
            found_in = 1'b1;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit) begin
         if (item_ff.last) begin
            count_in = '0;
         end else if (wr_en) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      found_ff  <= found_in;
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.commit) begin
         out_ff.value_out <= item_ff.value;
         out_ff.keep      <= !found_ff;
         out_ff.last_out  <= item_ff.last;
         out_ff.overflow  <= !found_ff && store_full;
      end
   end

   assign status.search_done = (rd_idx_ff >= count_ff) && !pending_ff;
   assign status.out_free    = !out_valid_ff || !rsp_stall;
   assign rsp_valid          = out_valid_ff;
   assign rsp_data           = out_ff;

endmodule

// ===== rtl/core/stream_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// stream_duplicate_filter
// Marks repeated values within a list that arrives as a stream of items.
//
// Items enter on the req_ channel (valid/stall) as a signed value and a flag
// that marks the last item of a list. Each item yields exactly one result on
// the rsp_ channel: the value, a keep flag (clear for a repeat), the last
// flag and an overflow flag (set when a new value could not be recorded
// because the store of seen values was full).
// The store holds the values recorded so far in the current list (0 to
// SEEN_DEPTH). The linear search reads one store entry per cycle from a RAM
// with registered read data and compares each entry in the cycle after it
// is read; an empty store leaves nothing to read. A commit step then
// registers the result. Items are handled one at a time and the next is
// accepted the cycle after the commit.
// A finished result sits in an output register; while the receiver stalls,
// the next item may still be accepted and searched, and its commit waits
// until the register is drained. Reset empties the store and clears the
// channels; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stream_duplicate_filter #(
   parameter int SEEN_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sdf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sdf_pkg::rsp_type rsp_data
);
   import sdf_pkg::*;

   cmd_type    cmd;
   status_type status;

   sdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sdf_dpath #(
      .SEEN_DEPTH (SEEN_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/stream_duplicate_filter_tb.sv =====
// ----------------------------------------------------------------------------
// stream_duplicate_filter_tb
// Self-checking testbench for the stream duplicate filter.
//
// Lists of signed values are streamed into the block. A directed opening
// covers the value extremes, repeats, lists of a single item and the end of
// a list. Random lists follow, most of them short and full of repeats, and
// some long enough to fill the store of seen values. A scoreboard keeps its
// own store of seen values, predicts the keep and overflow flags of every
// accepted item and compares each result with the oldest prediction.
// Both channels are idled at random in the first two of three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_duplicate_filter_tb;

   import sdf_pkg::*;

   localparam int SEEN_DEPTH  = 64;
   localparam int STALL_LIMIT = 4000;
   localparam int PHASE_ITEMS = 217;

   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   class dedup_board;
      logic signed [VALUE_WIDTH-1:0] seen_store [SEEN_DEPTH];
      int unsigned                   seen_total;
      rsp_type                       expected_q [$];
      int unsigned                   errors;

      function new();
         seen_total = 0;
         errors     = 0;
      endfunction

      function void note_item(req_type item);
         rsp_type want;
         bit      found;
         found = 1'b0;
         for (int i = 0; i < seen_total; i++) begin
            if (seen_store[i] == item.value) begin
               found = 1'b1;
            end
         end
         want.value_out = item.value;
         want.last_out  = item.last;
         want.keep      = !found;
         want.overflow  = 1'b0;
         if (!found) begin
            if (seen_total < SEEN_DEPTH) begin
               seen_store[seen_total] = item.value;
               seen_total++;
            end else begin
               want.overflow = 1'b1;
            end
         end
         if (item.last) begin
            seen_total = 0;
         end
         expected_q.push_back(want);
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result for value %0d with no item outstanding", got.value_out));
         end else begin
            want = expected_q.pop_front();
            if (got.value_out !== want.value_out) begin
               report($sformatf("value_out %0d, expected %0d", got.value_out, want.value_out));
            end
            if (got.keep !== want.keep) begin
               report($sformatf("keep %b for value %0d, expected %b",
                                got.keep, want.value_out, want.keep));
            end
            if (got.last_out !== want.last_out) begin
               report($sformatf("last_out %b for value %0d, expected %b",
                                got.last_out, want.value_out, want.last_out));
            end
            if (got.overflow !== want.overflow) begin
               report($sformatf("overflow %b for value %0d, expected %b",
                                got.overflow, want.value_out, want.overflow));
            end
         end
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   dedup_board  board = new();
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned items_sent;
   int unsigned stuck_cycles = 0;

   stream_duplicate_filter #(
      .SEEN_DEPTH(SEEN_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == STALL_LIMIT) begin
         $display("[stream_duplicate_filter] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so the next call never lowers and raises it at once.
   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      board.note_item(item);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value, input logic last);
      req_type item;
      item.value = value;
      item.last  = last;
      send_item(item);
   endtask

   task automatic send_random_list();
      logic signed [VALUE_WIDTH-1:0] pool [4];
      logic signed [VALUE_WIDTH-1:0] prev;
      req_type                       item;
      int unsigned                   len;
      int unsigned                   repeat_pct;
      int unsigned                   pick;
      if ($urandom_range(7) == 0) begin
         len        = $urandom_range(SEEN_DEPTH + 2, SEEN_DEPTH + 26);
         repeat_pct = 10;
      end else begin
         len        = $urandom_range(1, 16);
         repeat_pct = 50;
      end
      foreach (pool[k]) begin
         pool[k] = $urandom;
      end
      prev = pool[0];
      for (int n = 0; n < len; n++) begin
         pick = $urandom_range(99);
         if (pick < repeat_pct / 2) begin
            item.value = pool[$urandom_range(3)];
         end else if (pick < repeat_pct) begin
            item.value = prev;
         end else if (pick < repeat_pct + 5) begin
            case ($urandom_range(3))
               0: item.value = VALUE_MIN;
               1: item.value = VALUE_MAX;
               2: item.value = '0;
               default: item.value = '1;
            endcase
         end else begin
            item.value = $urandom;
         end
         item.last = (n == len - 1);
         send_item(item);
         prev = item.value;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 29;
      recv_idle_pct = 74;
      items_sent    = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Lists of one item; the second shows the store was emptied.
      send_value('0, 1'b1);
      send_value('0, 1'b1);
      // Extremes and alternating bit patterns, with repeats, closed by a repeat.
      send_value(VALUE_MIN, 1'b0);
      send_value(VALUE_MAX, 1'b0);
      send_value('1, 1'b0);
      send_value(1, 1'b0);
      send_value(VALUE_MIN, 1'b0);
      send_value(VALUE_MAX, 1'b0);
      send_value(32'sh5555_5555, 1'b0);
      send_value(32'shAAAA_AAAA, 1'b0);
      send_value('1, 1'b0);
      send_value('0, 1'b0);
      send_value('0, 1'b1);
      // The same value three times, then a new list that reuses it.
      send_value(7, 1'b0);
      send_value(7, 1'b0);
      send_value(7, 1'b1);
      send_value(7, 1'b0);
      send_value(VALUE_MIN, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (items_sent < PHASE_ITEMS * (phase + 1)) begin
            send_random_list();
         end
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SEEN_DEPTH + 8) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("[stream_duplicate_filter] OK");
      end else begin
         $display("[stream_duplicate_filter] ERROR");
      end
      $finish;
   end

endmodule
